[rtl/rfv_pkg.sv]
// Shared types and constants for the receive frame validator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package rfv_pkg;

  localparam int MIN_FRAME = 8;
  localparam int MAX_FRAME = 64;

  localparam int HDR_N = 5;
  localparam int CNT_W = $clog2(MAX_FRAME + 2);
  localparam int CMP_W = ((CNT_W > 9) ? CNT_W : 9) + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_HEAD   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TAIL   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MSG_ID = 2'd2;

  localparam logic [7:0] HEAD_RST   = 8'd170;
  localparam logic [7:0] TAIL_RST   = 8'd85;
  localparam logic [7:0] MSG_ID_RST = 8'd1;

  localparam int OUT_W = 48;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_HEAD_TAIL = 3'd2,
    ST_LENGTH    = 3'd3,
    ST_CHECKSUM  = 3'd4,
    ST_MSG_ID    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] head;
    logic [7:0] tail;
    logic [7:0] msg_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0]            first_byte;
    logic [7:0]            last_byte;
    logic [HDR_N-1:0][7:0] hdr;
    logic [15:0]           sum;
    logic [15:0]           cksum;
    logic [CNT_W-1:0]      count;
  } frame_rec_t;

endpackage

[rtl/rfv_front.sv]
// Front part: accepts received bytes, tracks count, sum and captured bytes,
// and hands one frame record to the queue on the last byte. Uses rfv_pkg.
`timescale 1ns / 1ps

module rfv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_acc,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               rec_push,
  output rfv_pkg::frame_rec_t rec
);

  logic [rfv_pkg::CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [15:0]                            sum_r, sum_nxt;
  logic [7:0]                             first_r, first_nxt;
  logic [rfv_pkg::HDR_N-1:0][7:0]         hdr_r, hdr_nxt;
  logic [7:0]                             ckh_r, ckh_nxt;
  logic [7:0]                             ckl_r, ckl_nxt;
  logic                                   active;
  logic [rfv_pkg::CMP_W-1:0]              posx;
  logic [rfv_pkg::CMP_W-1:0]              ck_pos;

  always_comb begin
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    first_nxt = first_r;
    hdr_nxt   = hdr_r;
    ckh_nxt   = ckh_r;
    ckl_nxt   = ckl_r;
    active    = (cnt_r < rfv_pkg::CNT_W'(rfv_pkg::MAX_FRAME));
    posx      = rfv_pkg::CMP_W'(cnt_r);
    if (active) begin
      if (cnt_r == '0) begin
        first_nxt = in_byte;
      end
      for (int i = 0; i < rfv_pkg::HDR_N; i++) begin
        if (cnt_r == rfv_pkg::CNT_W'(i + 1)) begin
          hdr_nxt[i] = in_byte;
        end
      end
    end
    // The length byte counts from the moment it arrives.
    ck_pos = rfv_pkg::CMP_W'(hdr_nxt[1]) + rfv_pkg::CMP_W'(5);
    if (active) begin
      if (posx < ck_pos) begin
        sum_nxt = sum_r + {8'd0, in_byte};
      end
      if (posx == ck_pos) begin
        ckh_nxt = in_byte;
      end
      if (posx == ck_pos + rfv_pkg::CMP_W'(1)) begin
        ckl_nxt = in_byte;
      end
      cnt_nxt = cnt_r + rfv_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    rec_push       = in_acc && in_last;
    rec.first_byte = first_nxt;
    rec.last_byte  = in_byte;
    rec.hdr        = hdr_nxt;
    rec.sum        = sum_nxt;
    rec.cksum      = {ckh_nxt, ckl_nxt};
    rec.count      = cnt_r + rfv_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_r   <= '0;
      first_r <= '0;
      hdr_r   <= '0;
      ckh_r   <= '0;
      ckl_r   <= '0;
    end else if (in_acc) begin
      if (in_last) begin
        cnt_r   <= '0;
        sum_r   <= '0;
        first_r <= '0;
        hdr_r   <= '0;
        ckh_r   <= '0;
        ckl_r   <= '0;
      end else begin
        cnt_r   <= cnt_nxt;
        sum_r   <= sum_nxt;
        first_r <= first_nxt;
        hdr_r   <= hdr_nxt;
        ckh_r   <= ckh_nxt;
        ckl_r   <= ckl_nxt;
      end
    end
  end

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rfv_pkg::CNT_W'(rfv_pkg::MAX_FRAME))
    else $error("byte count passed its saturation point");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (cnt_r == '0 && sum_r == '0 && hdr_r == '0))
    else $error("frame state not cleared after the last item");

endmodule

[rtl/rfv_queue.sv]
// Short queue of frame records between the front and back parts.
// Uses rfv_pkg for the record type and depth.
`timescale 1ns / 1ps

module rfv_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rfv_pkg::frame_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output rfv_pkg::frame_rec_t head_rec
);

  rfv_pkg::frame_rec_t        ent_r [rfv_pkg::QDEPTH];
  logic [rfv_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [rfv_pkg::QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == rfv_pkg::QCNT_W'(rfv_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + rfv_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + rfv_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + rfv_pkg::QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - rfv_pkg::QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");

endmodule

[rtl/rfv_back.sv]
// Back part: takes a frame record from the queue, runs the checks in order
// and holds the verdict in the output register. Uses rfv_pkg.
`timescale 1ns / 1ps

module rfv_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rfv_pkg::cfg_t               cfg,
  input  logic                        head_valid,
  input  rfv_pkg::frame_rec_t         head_rec,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rfv_pkg::OUT_W-1:0]   out_tdata
);

  rfv_pkg::status_t            status;
  rfv_pkg::status_t            status_r;
  logic                        ok_r;
  logic                        valid_r;
  logic [rfv_pkg::HDR_N-1:0][7:0] hdr_r;
  logic [rfv_pkg::CMP_W-1:0]   cntx;
  logic [rfv_pkg::CMP_W-1:0]   lenx;

  always_comb begin
    cntx = rfv_pkg::CMP_W'(head_rec.count);
    lenx = rfv_pkg::CMP_W'(head_rec.hdr[1]);
    if (cntx < rfv_pkg::CMP_W'(rfv_pkg::MIN_FRAME)) begin
      status = rfv_pkg::ST_SHORT;
    end else if (head_rec.first_byte != cfg.head || head_rec.last_byte != cfg.tail) begin
      status = rfv_pkg::ST_HEAD_TAIL;
    end else if (cntx > rfv_pkg::CMP_W'(rfv_pkg::MAX_FRAME)
                 || cntx < lenx + rfv_pkg::CMP_W'(rfv_pkg::MIN_FRAME)
                 || lenx > rfv_pkg::CMP_W'(rfv_pkg::MAX_FRAME - rfv_pkg::MIN_FRAME)) begin
      status = rfv_pkg::ST_LENGTH;
    end else if (head_rec.sum != head_rec.cksum) begin
      status = rfv_pkg::ST_CHECKSUM;
    end else if (head_rec.hdr[0] != cfg.msg_id) begin
      status = rfv_pkg::ST_MSG_ID;
    end else begin
      status = rfv_pkg::ST_OK;
    end
  end

  assign pop        = head_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, hdr_r[4], hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0],
                       status_r, ok_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= status;
      ok_r     <= (status == rfv_pkg::ST_OK);
      hdr_r    <= head_rec.hdr;
    end
  end

  a_ok_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (ok_r == (status_r == rfv_pkg::ST_OK)))
    else $error("frame_ok disagrees with status code");

  a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("verdict taken from queue but not presented");

endmodule

[rtl/rx_frame_validator.sv]
// Top level of the receive frame validator: configuration registers, front
// part, record queue and back part. Uses rfv_pkg, rfv_front, rfv_queue, rfv_back.
`timescale 1ns / 1ps

// The block takes one received byte per item, one item per cycle while
// in_tready is high, with in_tlast marking the last byte of a frame. For each
// frame it returns one verdict item: the clock edge that accepts the last byte
// writes the frame record into a two-entry queue, and the checks then run into
// the output register, raising out_tvalid, once that register is empty or its
// verdict is taken. While the output is not stalled, every byte is taken at once.
// in_tready falls, for any byte, only while the queue holds two frame records
// behind a stalled output, so a stalled output holds up to three frames before
// the input stops. Configuration writes complete in the cycle they are offered.
module rx_frame_validator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  input  logic                             in_tlast,   // frame_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] frame_ok, [3:1] status_code, [11:4] message_id, [19:12] payload_length,
  // [27:20] device_number, [35:28] sequence_number, [43:36] first_payload_byte
  output logic [rfv_pkg::OUT_W-1:0]        out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rfv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [7:0]                       cfg_data
);

  rfv_pkg::cfg_t       cfg_r;
  rfv_pkg::frame_rec_t rec;
  rfv_pkg::frame_rec_t head_rec;
  logic                rec_push;
  logic                q_full;
  logic                head_valid;
  logic                pop;
  logic                in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head   <= rfv_pkg::HEAD_RST;
      cfg_r.tail   <= rfv_pkg::TAIL_RST;
      cfg_r.msg_id <= rfv_pkg::MSG_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        rfv_pkg::REG_HEAD:   cfg_r.head   <= cfg_data;
        rfv_pkg::REG_TAIL:   cfg_r.tail   <= cfg_data;
        rfv_pkg::REG_MSG_ID: cfg_r.msg_id <= cfg_data;
        default:             cfg_r        <= cfg_r;
      endcase
    end
  end

  rfv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .rec_push (rec_push),
    .rec      (rec)
  );

  rfv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (rec_push),
    .push_rec   (rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  rfv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
